// ===== hdl/salfu_pkg.sv =====
// Shared types, constants and helpers for the set-associative LFU cache lookup.
// No dependencies; imported by every module of the block.

package salfu_pkg;

    localparam int DEF_MAX_SETS = 256;
    localparam int DEF_MAX_WAYS = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int OFFSET_W    = 5;
    localparam int INDEX_CFG_W = 4;
    localparam int WAYS_CFG_W  = 4;
    localparam int WAY_OUT_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int SHIFT_W     = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

    localparam logic [OFFSET_W-1:0]    OFFSET_LIMIT       = 5'd16;
    localparam logic [OFFSET_W-1:0]    OFFSET_RESET       = 5'd4;
    localparam logic [INDEX_CFG_W-1:0] SET_INDEX_RESET    = 4'd4;
    localparam logic [WAYS_CFG_W-1:0]  WAYS_RESET         = 4'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } back_state_t;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } way_entry_t;

    typedef struct packed {
        logic clearing;
        logic queue_full;
    } front_status_t;

    function automatic int floor_log2(input int n);
        int b;
        b = 0;
        while (b < 16 && (2 << b) <= n)
            b++;
        return b;
    endfunction

endpackage

// ===== hdl/set_assoc_cache_lookup_lfu_top.sv =====
// Top level of the set-associative cache lookup with LFU replacement.
// Depends on salfu_pkg, salfu_front, salfu_queue and salfu_back.
//
// Usage:
//   Command channel: drive access_address with start high; the word is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with is_hit, way_used
//   and access_number; the receiver cannot stall, so it must sample then.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while no lookup is outstanding.
//   A word accepted with the queue empty passes the back part's set read
//   (ST_IDLE) and its match and write-back (ST_LOOKUP) before done rises.
//   One lookup at a time: the single-port set memory is read, then written.
//   A two-word queue lets the front accept while the back works; busy is high
//   while the queue is full.
//   Reset: clears configuration to offset 4, index 4, one way, the access
//   count to zero, then runs a clearing pass over all MAX_SETS rows of the
//   set memory, during which busy stays high.

module set_assoc_cache_lookup_lfu_top
    import salfu_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ADDR_W-1:0]      access_address,
    output logic                   done,
    output logic                   is_hit,
    output logic [WAY_OUT_W-1:0]   way_used,
    output logic [ADDR_W-1:0]      access_number,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ITEM_W = SET_W + TAG_W + WCNT_W;

    front_status_t     status;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              clearing;
    logic [SET_W-1:0]  item_set;
    logic [TAG_W-1:0]  item_tag;
    logic [WCNT_W-1:0] item_ways;
    logic [SET_W-1:0]  q_set;
    logic [TAG_W-1:0]  q_tag;
    logic [WCNT_W-1:0] q_ways;
    logic [ITEM_W-1:0] q_data;

    assign status.clearing   = clearing;
    assign status.queue_full = q_full;
    assign {q_set, q_tag, q_ways} = q_data;

    salfu_front #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .access_address (access_address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .status         (status),
        .push           (push),
        .item_set       (item_set),
        .item_tag       (item_tag),
        .item_ways      (item_ways)
    );

    salfu_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({item_set, item_tag, item_ways}),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    salfu_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_set         (q_set),
        .q_tag         (q_tag),
        .q_ways        (q_ways),
        .pop           (pop),
        .clearing      (clearing),
        .done          (done),
        .is_hit        (is_hit),
        .way_used      (way_used),
        .access_number (access_number)
    );

endmodule

// ===== hdl/salfu_queue.sv =====
// Short FIFO between the front and back parts of the cache lookup.
// Depends on salfu_pkg.

module salfu_queue
    import salfu_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/salfu_front.sv =====
// Front part: configuration registers, command acceptance, set and tag split.
// Depends on salfu_pkg.

module salfu_front
    import salfu_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ADDR_W-1:0]      access_address,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  front_status_t          status,
    output logic                   push,
    output logic [SET_W-1:0]       item_set,
    output logic [TAG_W-1:0]       item_tag,
    output logic [WCNT_W-1:0]      item_ways
);

    localparam logic [OFFSET_W-1:0] INDEX_LIMIT = OFFSET_W'(floor_log2(MAX_SETS));
    localparam logic [OFFSET_W-1:0] WAYS_LIMIT  = OFFSET_W'(MAX_WAYS);

    logic [OFFSET_W-1:0]    offset_bits_reg;
    logic [INDEX_CFG_W-1:0] set_index_bits_reg;
    logic [WAYS_CFG_W-1:0]  ways_in_use_reg;

    logic [OFFSET_W-1:0] ob;
    logic [OFFSET_W-1:0] ib;
    logic [OFFSET_W-1:0] wv;
    logic [ADDR_W-1:0]   shifted;
    logic [ADDR_W-1:0]   set_mask;
    logic [ADDR_W-1:0]   set_full;

    assign cfg_ready = 1'b1;
    assign busy      = status.clearing | status.queue_full;
    assign push      = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg    <= OFFSET_RESET;
            set_index_bits_reg <= SET_INDEX_RESET;
            ways_in_use_reg    <= WAYS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data;
                CFG_SET_INDEX_BITS: set_index_bits_reg <= cfg_data[INDEX_CFG_W-1:0];
                CFG_WAYS_IN_USE:    ways_in_use_reg    <= cfg_data[WAYS_CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        ob = (offset_bits_reg > OFFSET_LIMIT) ? OFFSET_LIMIT : offset_bits_reg;
        ib = ({1'b0, set_index_bits_reg} > INDEX_LIMIT) ? INDEX_LIMIT
                                                        : {1'b0, set_index_bits_reg};
        wv = {1'b0, ways_in_use_reg};
        if (wv == '0)
        begin
            wv = OFFSET_W'(1);
        end
        else if (wv > WAYS_LIMIT)
        begin
            wv = WAYS_LIMIT;
        end
        shifted   = access_address >> ob;
        set_mask  = (ADDR_W'(1) << ib) - ADDR_W'(1);
        set_full  = shifted & set_mask;
        item_set  = set_full[SET_W-1:0];
        item_tag  = access_address >> ({1'b0, ob} + {1'b0, ib});
        item_ways = wv[WCNT_W-1:0];
    end

endmodule

// ===== hdl/salfu_back.sv =====
// Back part: set memory with clearing pass, tag match, LFU victim pick, update.
// Depends on salfu_pkg.

module salfu_back
    import salfu_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [SET_W-1:0]     q_set,
    input  logic [TAG_W-1:0]     q_tag,
    input  logic [WCNT_W-1:0]    q_ways,
    output logic                 pop,
    output logic                 clearing,
    output logic                 done,
    output logic                 is_hit,
    output logic [WAY_OUT_W-1:0] way_used,
    output logic [ADDR_W-1:0]    access_number
);

    way_entry_t [MAX_WAYS-1:0] row_mem [MAX_SETS];
    way_entry_t [MAX_WAYS-1:0] row_rd_reg;
    way_entry_t [MAX_WAYS-1:0] new_row;
    way_entry_t [MAX_WAYS-1:0] mem_wd;

    back_state_t state_reg, state_next;
    logic [SET_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [ADDR_W-1:0] access_count_reg, access_count_next;
    logic              done_reg;
    logic              is_hit_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [SET_W-1:0]  cur_set_reg;
    logic [TAG_W-1:0]  cur_tag_reg;
    logic [WCNT_W-1:0] cur_ways_reg;

    logic              mem_we;
    logic              mem_re;
    logic              fire;
    logic [SET_W-1:0]  mem_wa;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] cand;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  used;
    logic [WAY_W+WAY_OUT_W-1:0] way_ext;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        pop      = 1'b0;
        fire     = 1'b0;
        clearing = 1'b0;
        mem_wa   = cur_set_reg;
        mem_wd   = new_row;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                mem_wa   = clr_idx_reg;
                mem_wd   = '0;
            end
            ST_IDLE:
            begin
                pop    = ~q_empty;
                mem_re = ~q_empty;
            end
            ST_LOOKUP:
            begin
                mem_we = 1'b1;
                fire   = 1'b1;
            end
            default: clearing = 1'b1;
        endcase
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = WCNT_W'(w) < cur_ways_reg;
            match[w]  = in_use[w] && row_rd_reg[w].valid && (row_rd_reg[w].tag == cur_tag_reg);
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            cand[w] = in_use[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (in_use[v] && v < w && !(row_rd_reg[w].count < row_rd_reg[v].count))
                begin
                    cand[w] = 1'b0;
                end
                if (in_use[v] && v > w && (row_rd_reg[v].count < row_rd_reg[w].count))
                begin
                    cand[w] = 1'b0;
                end
            end
        end
        hit     = |match;
        hit_way = '0;
        victim  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (cand[w])
            begin
                victim = WAY_W'(w);
            end
        end
        used    = hit ? hit_way : victim;
        new_row = row_rd_reg;
        if (hit)
        begin
            if (row_rd_reg[hit_way].count != '1)
            begin
                new_row[hit_way].count = row_rd_reg[hit_way].count + 1'b1;
            end
        end
        else
        begin
            new_row[victim].valid = 1'b1;
            new_row[victim].tag   = cur_tag_reg;
            new_row[victim].count = COUNT_W'(1);
        end
        clr_idx_next      = clr_idx_reg + 1'b1;
        access_count_next = fire ? access_count_reg + 1'b1 : access_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            access_count_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            access_count_reg <= access_count_next;
            done_reg         <= fire;
            if (clearing)
            begin
                clr_idx_reg <= clr_idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_set_reg  <= q_set;
            cur_tag_reg  <= q_tag;
            cur_ways_reg <= q_ways;
        end
        if (fire)
        begin
            is_hit_reg <= hit;
            way_reg    <= used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            row_rd_reg <= row_mem[q_set];
        end
    end

    assign way_ext       = {{WAY_OUT_W{1'b0}}, way_reg};
    assign done          = done_reg;
    assign is_hit        = is_hit_reg;
    assign way_used      = way_ext[WAY_OUT_W-1:0];
    assign access_number = access_count_reg;

endmodule

// ===== hdl/salfu_checker.sv =====
// Port-level checks on the cache lookup top level, attached by bind.
// Depends on salfu_pkg and set_assoc_cache_lookup_lfu_top.

module salfu_checker
    import salfu_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   busy,
    input logic                   done,
    input logic [ADDR_W-1:0]      access_number,
    input logic                   cfg_ready
);

    // hold off commands while the clearing pass runs
    assert property (@(posedge clk) !rst_n |=> busy)
        else $error("busy low straight after reset");

    // drop no result before the memory is cleared
    assert property (@(posedge clk) !rst_n |=> !done)
        else $error("result strobe straight after reset");

    // never raise done in consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe on consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done, 2) |-> access_number == $past(access_number, 2) + 32'd1)
        else $error("access number skipped between back-to-back results");

    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind set_assoc_cache_lookup_lfu_top salfu_checker u_salfu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .access_number (access_number),
    .cfg_ready     (cfg_ready)
);

// ===== tb/set_assoc_cache_lookup_lfu_top_tb.sv =====
// Testbench for set_assoc_cache_lookup_lfu_top: directed and random address words
// checked against an LFU cache predictor in a small scoreboard class.
// Depends on salfu_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module set_assoc_cache_lookup_lfu_top_tb;
    import salfu_pkg::*;

    localparam int ENTRIES       = DEF_MAX_SETS * DEF_MAX_WAYS;
    localparam int SET_BITS_MAX  = $clog2(DEF_MAX_SETS);
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 175;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [ADDR_W-1:0]    number;
    } lookup_outcome_t;

    class lfu_lookup_scoreboard;
        bit                  entry_valid [ENTRIES];
        bit [TAG_W-1:0]      entry_tag   [ENTRIES];
        bit [COUNT_W-1:0]    entry_uses  [ENTRIES];
        bit [ADDR_W-1:0]     access_count;
        bit [OFFSET_W-1:0]   offset_reg;
        bit [INDEX_CFG_W-1:0] index_reg;
        bit [WAYS_CFG_W-1:0] ways_reg;
        lookup_outcome_t     pending_outcomes [$];
        int                  mismatches;
        int                  checked;
        int                  hits;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_valid[i] = 1'b0;
                entry_tag[i]   = '0;
                entry_uses[i]  = '0;
            end
            access_count = '0;
            offset_reg   = OFFSET_RESET;
            index_reg    = SET_INDEX_RESET;
            ways_reg     = WAYS_RESET;
            mismatches   = 0;
            checked      = 0;
            hits         = 0;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_OFFSET_BITS:    offset_reg = value[OFFSET_W-1:0];
                CFG_SET_INDEX_BITS: index_reg  = value[INDEX_CFG_W-1:0];
                CFG_WAYS_IN_USE:    ways_reg   = value[WAYS_CFG_W-1:0];
                default:            ;
            endcase
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        function void record_access(input logic [ADDR_W-1:0] addr);
            int              ofs_eff;
            int              idx_eff;
            int              span;
            int              set_no;
            int              base;
            int              victim;
            bit              found;
            bit [TAG_W-1:0]  tag_val;
            bit [COUNT_W-1:0] least;
            lookup_outcome_t outcome;

            ofs_eff = int'(offset_reg);
            if (ofs_eff > int'(OFFSET_LIMIT))
                ofs_eff = int'(OFFSET_LIMIT);
            idx_eff = int'(index_reg);
            if (idx_eff > SET_BITS_MAX)
                idx_eff = SET_BITS_MAX;
            span = int'(ways_reg);
            if (span == 0)
                span = 1;
            if (span > DEF_MAX_WAYS)
                span = DEF_MAX_WAYS;

            set_no  = int'((addr >> ofs_eff) & ((32'd1 << idx_eff) - 32'd1));
            tag_val = addr >> (ofs_eff + idx_eff);
            base    = set_no * DEF_MAX_WAYS;

            found  = 1'b0;
            victim = 0;
            for (int w = 0; w < span && !found; w++)
            begin
                if (entry_valid[base + w] && entry_tag[base + w] == tag_val)
                begin
                    found  = 1'b1;
                    victim = w;
                    if (entry_uses[base + w] != 32'hFFFF_FFFF)
                        entry_uses[base + w]++;
                end
            end

            if (!found)
            begin
                least = entry_uses[base];
                for (int w = 1; w < span; w++)
                begin
                    if (entry_uses[base + w] < least)
                    begin
                        least  = entry_uses[base + w];
                        victim = w;
                    end
                end
                entry_valid[base + victim] = 1'b1;
                entry_tag[base + victim]   = tag_val;
                entry_uses[base + victim]  = 32'd1;
            end

            access_count++;
            outcome.hit    = found;
            outcome.way    = victim[WAY_OUT_W-1:0];
            outcome.number = access_count;
            pending_outcomes.push_back(outcome);
        endfunction

        function void check_outcome(input logic hit, input logic [WAY_OUT_W-1:0] way,
                                    input logic [ADDR_W-1:0] number);
            lookup_outcome_t want;

            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: hit %0b way %0d number %0d",
                         $time, hit, way, number);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            if (want.hit)
                hits++;
            if (hit !== want.hit)
            begin
                $display("%0t: is_hit expected %0b actual %0b", $time, want.hit, hit);
                mismatches++;
            end
            if (way !== want.way)
            begin
                $display("%0t: way_used expected %0d actual %0d", $time, want.way, way);
                mismatches++;
            end
            if (number !== want.number)
            begin
                $display("%0t: access_number expected %0d actual %0d",
                         $time, want.number, number);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ADDR_W-1:0]      access_address = '0;
    logic                   done;
    logic                   is_hit;
    logic [WAY_OUT_W-1:0]   way_used;
    logic [ADDR_W-1:0]      access_number;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    lfu_lookup_scoreboard sb = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int settings_applied = 0;

    set_assoc_cache_lookup_lfu_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .access_address (access_address),
        .done           (done),
        .is_hit         (is_hit),
        .way_used       (way_used),
        .access_number  (access_number),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_outcome(is_hit, way_used, access_number);
            if (start && !busy)
                sb.record_access(access_address);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // drive one address word; start stays high across back-to-back words
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        int gap;

        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        access_address <= addr;
        do
            @(posedge clk);
        while (busy);
    endtask

    // drop start and hold until every lookup has returned
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] ofs_data,
                                 input logic [CFG_DATA_W-1:0] idx_data,
                                 input logic [CFG_DATA_W-1:0] ways_data,
                                 input bit touch_spare);
        logic [CFG_INDEX_W-1:0] idx_list  [4];
        logic [CFG_DATA_W-1:0]  data_list [4];
        int                     n;

        idx_list[0] = CFG_OFFSET_BITS;    data_list[0] = ofs_data;
        idx_list[1] = CFG_SET_INDEX_BITS; data_list[1] = idx_data;
        idx_list[2] = CFG_WAYS_IN_USE;    data_list[2] = ways_data;
        idx_list[3] = CFG_SPARE;          data_list[3] = 5'd31;
        n = touch_spare ? 4 : 3;
        for (int k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= data_list[k];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address(input int ofs_cfg, input int idx_cfg,
                                                        input int tag_span);
        int                ofs;
        int                idx;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] set_sel;
        logic [ADDR_W-1:0] tag_sel;

        a = $urandom;
        if ($urandom_range(0, 7) == 0)
            return a;
        ofs = ofs_cfg > 16 ? 16 : ofs_cfg;
        idx = idx_cfg > SET_BITS_MAX ? SET_BITS_MAX : idx_cfg;
        low_mask = (32'd1 << ofs) - 32'd1;
        set_sel  = $urandom_range(0, 3);
        set_sel  = set_sel & ((32'd1 << idx) - 32'd1);
        tag_sel  = $urandom_range(0, tag_span);
        if ($urandom_range(0, 15) == 0)
            tag_sel = $urandom;
        return (a & low_mask) | (set_sel << ofs) | (tag_sel << (ofs + idx));
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] ph_ofs  [PHASES] = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd17,
                                                    5'd2, 5'd12, 5'd0, 5'd16, 5'd4};
        logic [CFG_DATA_W-1:0] ph_idx  [PHASES] = '{5'd0, 5'd8, 5'd15, 5'd19, 5'd9,
                                                    5'd1, 5'd6, 5'd8, 5'd0, 5'd4};
        logic [CFG_DATA_W-1:0] ph_ways [PHASES] = '{5'd1, 5'd8, 5'd16, 5'd15, 5'd4,
                                                    5'd2, 5'd31, 5'd3, 5'd8, 5'd1};
        logic [ADDR_W-1:0] opening [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                           32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_0100};
        logic [ADDR_W-1:0] lfu_run [10] = '{32'h00, 32'h10, 32'h20, 32'h30, 32'h00,
                                            32'h00, 32'h10, 32'h40, 32'h20, 32'h04};
        int span;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        foreach (opening[i])
            send_access(opening[i]);
        drain();

        apply_setting(5'd2, 5'd2, 5'd4, 1'b0);
        foreach (lfu_run[i])
            send_access(lfu_run[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            apply_setting(ph_ofs[p], ph_idx[p], ph_ways[p], p == 2);
            span = int'(ph_ways[p][3:0]);
            if (span == 0)
                span = 1;
            if (span > DEF_MAX_WAYS)
                span = DEF_MAX_WAYS;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_access(pick_address(int'(ph_ofs[p]), int'(ph_idx[p][3:0]), span + 3));
            drain();
        end

        repeat (8) @(posedge clk);

        $display("Ran %0d lookups (%0d hits) across %0d register settings",
                 sb.checked, sb.hits, settings_applied);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/salfu_pkg.sv
hdl/salfu_queue.sv
hdl/salfu_front.sv
hdl/salfu_back.sv
hdl/set_assoc_cache_lookup_lfu_top.sv
hdl/salfu_checker.sv
tb/set_assoc_cache_lookup_lfu_top_tb.sv
